>>> sv/sha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg: shared types and constants for the segment hole allocator
// Holds the segment entry type, status codes and sequencer states.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int          MAX_SEGMENTS_DEF = 32;
    localparam int          UNIT_SIZE_KB_DEF = 1;
    localparam logic [13:0] TOTAL_RESET      = 14'd10240;

    typedef enum logic [3:0] {
        ST_AT_START   = 4'd0,
        ST_SPLIT      = 4'd1,
        ST_NO_HOLE    = 4'd2,
        ST_MERGE_BOTH = 4'd3,
        ST_MERGE_LEFT = 4'd4,
        ST_MERGE_RGHT = 4'd5,
        ST_NO_MERGE   = 4'd6,
        ST_NOT_FOUND  = 4'd7,
        ST_FULL       = 4'd8
    } t_status;

    typedef struct packed {
        logic        hole;
        logic [15:0] owner;
        logic [13:0] start;
        logic [13:0] len;
    } t_seg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_RD,
        S_CHK,
        S_FRD_L,
        S_FRD_R,
        S_FDEC,
        S_SHIFT,
        S_WRITE,
        S_OUT
    } t_state;

    localparam logic OP_ALLOC = 1'b0;

endpackage

>>> sv/segment_hole_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_hole_allocator_unit: first-fit segment allocator with coalescing
// Address-ordered segment table in one memory, scanned and shifted one entry
// at a time by a small sequencer.
// ----------------------------------------------------------------------------
// Each entry scanned is read and then checked, each entry moved is read and
// then written, and the status is then handed to the output register from S_OUT.
// Flow: one word in flight; the next word can be taken once the block is back in
// idle, while the previous status waits in its own output register.
// Reset: synchronous active low; total_units returns to 10240 and the table
// becomes one hole covering it via S_CLEAR. Config writes rebuild it the same way.
module segment_hole_allocator_unit #(
    parameter int MAX_SEGMENTS = sha_pkg::MAX_SEGMENTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [15:0] i_owner_id,
    input  logic [13:0] i_start_unit,
    input  logic [13:0] i_length_units,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [13:0] i_cfg_total_units
);

    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);

    // table memory: one write port, one registered read port
    sha_pkg::t_seg r_mem [MAX_SEGMENTS];
    sha_pkg::t_seg r_rdata;
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    sha_pkg::t_seg w_wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[w_raddr];
    end

    sha_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_idx, n_idx;      // scan position
    logic [CW-1:0]   r_sp, n_sp;        // shift pointer
    logic [CW-1:0]   r_lim, n_lim;      // shift end
    logic [1:0]      r_n, n_n;          // entries opened or removed
    logic            r_ins, n_ins;      // 1 insert (shift up), 0 remove
    logic [1:0]      r_wk, n_wk;        // write-phase step
    logic [13:0]     r_total, n_total;
    logic            r_op;
    logic [15:0]     r_id;
    logic [13:0]     r_st, r_ln;
    sha_pkg::t_seg   r_cur, n_cur, r_lft, n_lft, r_rgt, n_rgt;
    logic            r_lh, n_lh, r_rh, n_rh;
    logic [3:0]      r_stat, n_stat;
    logic            r_ov, n_ov;
    logic [3:0]      r_out, n_out;      // status word waiting at the output

    logic [14:0] w_hend, w_rend;
    logic [13:0] w_after;
    logic        w_fit;

    // hold off input while busy or while a config word is offered
    assign o_stall     = (r_state != sha_pkg::S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == sha_pkg::S_IDLE) && !r_ov;
    assign o_valid     = r_ov;
    assign o_status    = r_out;

    assign w_hend  = {1'b0, r_rdata.start} + {1'b0, r_rdata.len};
    assign w_rend  = {1'b0, r_st} + {1'b0, r_ln};
    assign w_after = w_hend[13:0] - w_rend[13:0];
    assign w_fit   = r_rdata.hole && (r_rdata.start <= r_st) && (w_rend <= w_hend);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha_pkg::S_CLEAR;
            r_total <= sha_pkg::TOTAL_RESET;
            r_cnt   <= CW'(1);
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_op <= i_opcode;
            r_id <= i_owner_id;
            r_st <= i_start_unit;
            r_ln <= i_length_units;
        end
        r_idx <= n_idx; r_sp <= n_sp; r_lim <= n_lim; r_n <= n_n; r_ins <= n_ins;
        r_wk <= n_wk; r_cur <= n_cur; r_lft <= n_lft; r_rgt <= n_rgt;
        r_lh <= n_lh; r_rh <= n_rh; r_stat <= n_stat; r_out <= n_out;
    end

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_total = r_total; n_ov = r_ov;
        n_idx = r_idx; n_sp = r_sp; n_lim = r_lim; n_n = r_n; n_ins = r_ins;
        n_wk = r_wk; n_cur = r_cur; n_lft = r_lft; n_rgt = r_rgt;
        n_lh = r_lh; n_rh = r_rh; n_stat = r_stat; n_out = r_out;
        w_we = 1'b0; w_waddr = '0; w_wdata = '0; w_raddr = r_idx[AW-1:0];
        if (r_ov && !i_stall) n_ov = 1'b0;
        unique case (r_state)
            sha_pkg::S_IDLE: begin
                if (i_cfg_valid && o_cfg_ready) begin
                    n_total = i_cfg_total_units;
                    n_state = sha_pkg::S_CLEAR;
                end else if (i_valid && !o_stall) begin
                    n_idx   = '0;
                    w_raddr = '0;
                    n_state = sha_pkg::S_CHK;
                    if (r_cnt == '0) n_state = sha_pkg::S_OUT;
                end
            end
            sha_pkg::S_CLEAR: begin
                // rebuild: one hole covering all units
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = '{hole: 1'b1, owner: 16'd0, start: 14'd0, len: r_total};
                n_cnt   = CW'(1);
                n_state = sha_pkg::S_IDLE;
            end
            sha_pkg::S_RD: begin
                w_raddr = r_idx[AW-1:0];
                n_state = sha_pkg::S_CHK;
            end
            sha_pkg::S_CHK: begin
                n_cur = r_rdata;
                if (r_op == sha_pkg::OP_ALLOC) begin
                    if (w_fit) begin
                        if (r_rdata.start == r_st) begin
                            n_n = 2'd1; n_sp = r_cnt; n_lim = r_idx;
                        end else begin
                            n_n = (w_after != 14'd0) ? 2'd2 : 2'd1;
                            n_sp = r_cnt; n_lim = r_idx + CW'(1);
                        end
                        n_stat = (r_rdata.start == r_st) ? 4'(sha_pkg::ST_AT_START)
                                                         : 4'(sha_pkg::ST_SPLIT);
                        n_ins = 1'b1; n_wk = '0;
                        n_state = sha_pkg::S_SHIFT;
                        if ({1'b0, r_cnt} + {{(CW-1){1'b0}}, n_n} > {1'b0, MAXC}) begin
                            n_stat = 4'(sha_pkg::ST_FULL);
                            n_state = sha_pkg::S_OUT;
                        end
                    end else if (r_idx + CW'(1) >= r_cnt) begin
                        n_stat = 4'(sha_pkg::ST_NO_HOLE);
                        n_state = sha_pkg::S_OUT;
                    end else begin
                        n_idx = r_idx + CW'(1);
                        n_state = sha_pkg::S_RD;
                    end
                end else begin
                    if (!r_rdata.hole && r_rdata.owner == r_id) begin
                        n_lh = 1'b0; n_rh = 1'b0;
                        n_state = sha_pkg::S_FRD_L;
                    end else if (r_idx + CW'(1) >= r_cnt) begin
                        n_stat = 4'(sha_pkg::ST_NOT_FOUND);
                        n_state = sha_pkg::S_OUT;
                    end else begin
                        n_idx = r_idx + CW'(1);
                        n_state = sha_pkg::S_RD;
                    end
                end
            end
            sha_pkg::S_FRD_L: begin
                // fetch left neighbor
                w_raddr = AW'(r_idx - CW'(1));
                n_state = sha_pkg::S_FRD_R;
            end
            sha_pkg::S_FRD_R: begin
                n_lft = r_rdata;
                n_lh  = (r_idx != '0) && r_rdata.hole;
                w_raddr = AW'(r_idx + CW'(1));
                n_state = sha_pkg::S_FDEC;
            end
            sha_pkg::S_FDEC: begin
                n_rgt = r_rdata;
                n_rh  = (r_idx + CW'(1) < r_cnt) && r_rdata.hole;
                n_ins = 1'b0; n_wk = '0;
                if (r_lh && n_rh) begin
                    w_we = 1'b1; w_waddr = AW'(r_idx - CW'(1)); w_wdata = r_lft;
                    w_wdata.len = r_lft.len + r_cur.len + r_rdata.len;
                    n_n = 2'd2; n_sp = r_idx; n_stat = 4'(sha_pkg::ST_MERGE_BOTH);
                    n_state = sha_pkg::S_SHIFT;
                end else if (r_lh) begin
                    w_we = 1'b1; w_waddr = AW'(r_idx - CW'(1)); w_wdata = r_lft;
                    w_wdata.len = r_lft.len + r_cur.len;
                    n_n = 2'd1; n_sp = r_idx; n_stat = 4'(sha_pkg::ST_MERGE_LEFT);
                    n_state = sha_pkg::S_SHIFT;
                end else if (n_rh) begin
                    // write merged hole over the region, then drop the old hole
                    w_we = 1'b1; w_waddr = r_idx[AW-1:0]; w_wdata = r_rdata;
                    w_wdata.len = r_rdata.len + r_cur.len;
                    w_wdata.start = r_cur.start;
                    n_n = 2'd1; n_sp = r_idx + CW'(1); n_stat = 4'(sha_pkg::ST_MERGE_RGHT);
                    n_state = sha_pkg::S_SHIFT;
                end else begin
                    w_we = 1'b1; w_waddr = r_idx[AW-1:0]; w_wdata = r_cur;
                    w_wdata.hole = 1'b1; w_wdata.owner = '0;
                    n_stat = 4'(sha_pkg::ST_NO_MERGE);
                    n_state = sha_pkg::S_OUT;
                end
                n_lim = r_cnt;
            end
            sha_pkg::S_SHIFT: begin
                // each moved entry is read, then written
                if (r_ins) begin
                    if (r_sp <= r_lim) begin
                        n_cnt = r_cnt + CW'(r_n);
                        n_wk = '0;
                        n_state = sha_pkg::S_WRITE;
                    end else if (r_wk == 2'd0) begin
                        w_raddr = AW'(r_sp - CW'(1));
                        n_wk = 2'd1;
                    end else begin
                        w_we = 1'b1; w_waddr = AW'(r_sp - CW'(1) + CW'(r_n));
                        w_wdata = r_rdata;
                        n_sp = r_sp - CW'(1);
                        n_wk = 2'd0;
                    end
                end else begin
                    if (r_sp + CW'(r_n) >= r_lim) begin
                        n_cnt = r_cnt - CW'(r_n);
                        n_state = sha_pkg::S_OUT;
                    end else if (r_wk == 2'd0) begin
                        w_raddr = AW'(r_sp + CW'(r_n));
                        n_wk = 2'd1;
                    end else begin
                        w_we = 1'b1; w_waddr = r_sp[AW-1:0]; w_wdata = r_rdata;
                        n_sp = r_sp + CW'(1);
                        n_wk = 2'd0;
                    end
                end
            end
            sha_pkg::S_WRITE: begin
                n_wk = r_wk + 2'd1;
                if (r_stat == 4'(sha_pkg::ST_AT_START)) begin
                    if (r_wk == 2'd0) begin
                        w_we = 1'b1; w_waddr = r_idx[AW-1:0];
                        w_wdata = '{hole: 1'b0, owner: r_id, start: r_st, len: r_ln};
                    end else begin
                        w_we = 1'b1; w_waddr = AW'(r_idx + CW'(1)); w_wdata = r_cur;
                        w_wdata.start = r_cur.start + r_ln;
                        w_wdata.len   = r_cur.len - r_ln;
                        n_state = sha_pkg::S_OUT;
                    end
                end else begin
                    unique case (r_wk)
                        2'd0: begin
                            w_we = 1'b1; w_waddr = r_idx[AW-1:0]; w_wdata = r_cur;
                            w_wdata.len = r_st - r_cur.start;
                        end
                        2'd1: begin
                            w_we = 1'b1; w_waddr = AW'(r_idx + CW'(1));
                            w_wdata = '{hole: 1'b0, owner: r_id, start: r_st, len: r_ln};
                            if (r_n == 2'd1) n_state = sha_pkg::S_OUT;
                        end
                        default: begin
                            w_we = 1'b1; w_waddr = AW'(r_idx + CW'(2));
                            w_wdata = '{hole: 1'b1, owner: 16'd0,
                                        start: w_rend[13:0],
                                        len: (r_cur.start + r_cur.len) - w_rend[13:0]};
                            n_state = sha_pkg::S_OUT;
                        end
                    endcase
                end
            end
            sha_pkg::S_OUT: begin
                // hold the status until the output register is free
                if (!r_ov || !i_stall) begin
                    n_ov    = 1'b1;
                    n_out   = r_stat;
                    n_state = sha_pkg::S_IDLE;
                end
            end
            default: n_state = sha_pkg::S_IDLE;
        endcase
    end

endmodule

>>> verif/segment_hole_allocator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_hole_allocator_unit_tb: self-checking bench for the segment allocator
// Drives allocate and free words against a local first-fit segment table,
// predicts every status word and checks it in order. Covers extreme memory
// sizes, every merge case, a full table, long back pressure and random traffic.
// ----------------------------------------------------------------------------
module segment_hole_allocator_unit_tb;

    localparam int   SEG_DEPTH  = sha_pkg::MAX_SEGMENTS_DEF;
    localparam int   IDLE_LIMIT = 5000;
    localparam logic OP_FREE    = 1'b1;

    typedef struct {
        logic        op;
        logic [15:0] id;
        logic [13:0] st;
        logic [13:0] ln;
    } seg_request_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_opcode = sha_pkg::OP_ALLOC;
    logic [15:0] i_owner_id = '0;
    logic [13:0] i_start_unit = '0;
    logic [13:0] i_length_units = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [3:0]  o_status;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [13:0] i_cfg_total_units = '0;

    // Local copy of the segment table and the memory size it was built from.
    sha_pkg::t_seg seg_tbl [SEG_DEPTH];
    int            seg_cnt;
    logic [13:0]   mem_units;

    sha_pkg::t_status status_q[$];
    int        mismatch_count = 0;
    bit        quiet = 0;
    int        hold_cycles = 0;
    int        rx_burst = 0;
    int        idle_cycles = 0;

    segment_hole_allocator_unit u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_opcode          (i_opcode),
        .i_owner_id        (i_owner_id),
        .i_start_unit      (i_start_unit),
        .i_length_units    (i_length_units),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_total_units (i_cfg_total_units)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Table predictor
    // ------------------------------------------------------------------
    function automatic void rebuild_table(logic [13:0] units);
        mem_units = units;
        foreach (seg_tbl[j]) seg_tbl[j] = '0;
        seg_tbl[0].hole = 1'b1;
        seg_tbl[0].len  = units;
        seg_cnt = 1;
    endfunction

    // Shift entries up from pos to make n free slots.
    function automatic void open_slots(int pos, int n);
        for (int j = seg_cnt - 1; j >= pos; j--) seg_tbl[j + n] = seg_tbl[j];
        seg_cnt += n;
    endfunction

    function automatic void drop_slot(int pos);
        for (int j = pos; j < seg_cnt - 1; j++) seg_tbl[j] = seg_tbl[j + 1];
        seg_cnt -= 1;
    endfunction

    function automatic sha_pkg::t_status carve_region(logic [15:0] id, logic [13:0] st,
                                                      logic [13:0] ln);
        sha_pkg::t_seg h;
        int   hend;
        int   rest;
        int   need;
        for (int i = 0; i < seg_cnt; i++) begin
            h = seg_tbl[i];
            hend = int'(h.start) + int'(h.len);
            if (!h.hole || h.start > st || int'(st) + int'(ln) > hend) continue;
            if (st == h.start) begin
                if (seg_cnt + 1 > SEG_DEPTH) return sha_pkg::ST_FULL;
                open_slots(i, 1);
                seg_tbl[i] = '{hole: 1'b0, owner: id, start: st, len: ln};
                seg_tbl[i + 1].start = h.start + ln;
                seg_tbl[i + 1].len   = h.len - ln;
                return sha_pkg::ST_AT_START;
            end
            rest = hend - (int'(st) + int'(ln));
            need = (rest > 0) ? 2 : 1;
            if (seg_cnt + need > SEG_DEPTH) return sha_pkg::ST_FULL;
            open_slots(i + 1, need);
            seg_tbl[i].len = st - h.start;
            seg_tbl[i + 1] = '{hole: 1'b0, owner: id, start: st, len: ln};
            if (rest > 0)
                seg_tbl[i + 2] = '{hole: 1'b1, owner: 16'h0, start: st + ln,
                                   len: rest[13:0]};
            return sha_pkg::ST_SPLIT;
        end
        return sha_pkg::ST_NO_HOLE;
    endfunction

    function automatic sha_pkg::t_status release_region(logic [15:0] id);
        sha_pkg::t_seg r;
        bit   lh;
        bit   rh;
        for (int i = 0; i < seg_cnt; i++) begin
            r = seg_tbl[i];
            if (r.hole || r.owner != id) continue;
            lh = (i > 0) && seg_tbl[i - 1].hole;
            rh = (i + 1 < seg_cnt) && seg_tbl[i + 1].hole;
            if (lh && rh) begin
                seg_tbl[i - 1].len = seg_tbl[i - 1].len + r.len + seg_tbl[i + 1].len;
                drop_slot(i + 1);
                drop_slot(i);
                return sha_pkg::ST_MERGE_BOTH;
            end
            if (lh) begin
                seg_tbl[i - 1].len = seg_tbl[i - 1].len + r.len;
                drop_slot(i);
                return sha_pkg::ST_MERGE_LEFT;
            end
            if (rh) begin
                seg_tbl[i + 1].len   = seg_tbl[i + 1].len + r.len;
                seg_tbl[i + 1].start = r.start;
                drop_slot(i);
                return sha_pkg::ST_MERGE_RGHT;
            end
            // no neighbor hole: the region itself becomes the hole
            seg_tbl[i].hole  = 1'b1;
            seg_tbl[i].owner = '0;
            return sha_pkg::ST_NO_MERGE;
        end
        return sha_pkg::ST_NOT_FOUND;
    endfunction

    // ------------------------------------------------------------------
    // Watchdog: count cycles in which no handshake of any channel fires.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each accepted status word with the oldest one.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        sha_pkg::t_status want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (status_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected status word %0d", $realtime, o_status);
            end else begin
                want = status_q.pop_front();
                if (o_status !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: status expected %0d (%s) got %0d", $realtime,
                                 want, want.name(), o_status);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, a long hold on request, none when quiet.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else if (quiet) begin
            i_stall <= 1'b0;
        end else if (rx_burst > 0) begin
            rx_burst <= rx_burst - 1;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            rx_burst <= $urandom_range(0, 13);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Offer one word, hold it until accepted, then predict its status.
    task automatic send_word(seg_request_t r);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_opcode       <= r.op;
        i_owner_id     <= r.id;
        i_start_unit   <= r.st;
        i_length_units <= r.ln;
        do @(posedge i_clk); while (o_stall);
        if (r.op == sha_pkg::OP_ALLOC) status_q = {status_q, carve_region(r.id, r.st, r.ln)};
        else status_q = {status_q, release_region(r.id)};
    endtask

    task automatic alloc_word(logic [15:0] id, logic [13:0] st, logic [13:0] ln);
        send_word('{op: sha_pkg::OP_ALLOC, id: id, st: st, ln: ln});
    endtask

    task automatic free_word(logic [15:0] id);
        send_word('{op: OP_FREE, id: id, st: 14'($urandom), ln: 14'($urandom)});
    endtask

    // Drop valid and wait until every predicted status word has come back.
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Rewrite the memory size once the block is idle; the table is rebuilt.
    task automatic write_total(logic [13:0] units);
        drain();
        @(negedge i_clk);
        i_cfg_valid       <= 1'b1;
        i_cfg_total_units <= units;
        do @(posedge i_clk); while (!o_cfg_ready);
        rebuild_table(units);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed traffic: fit inside a live hole or free a live owner.
    function automatic seg_request_t pick_request();
        seg_request_t r;
        int holes[$];
        int owned[$];
        int k;
        int room;
        int roll;
        r.op = sha_pkg::OP_ALLOC;
        r.id = 16'($urandom_range(0, 7));
        r.st = 14'($urandom);
        r.ln = 14'($urandom);
        roll = $urandom_range(0, 9);
        for (int i = 0; i < seg_cnt; i++) begin
            if (seg_tbl[i].hole && seg_tbl[i].len != 0) holes = {holes, i};
            if (!seg_tbl[i].hole) owned = {owned, i};
        end
        if (roll < 6 && holes.size() != 0) begin
            k = holes[$urandom_range(0, holes.size() - 1)];
            r.st = seg_tbl[k].start;
            if ($urandom_range(0, 1)) r.st += 14'($urandom_range(0, seg_tbl[k].len - 1));
            room = int'(seg_tbl[k].start) + int'(seg_tbl[k].len) - int'(r.st);
            if ($urandom_range(0, 3) == 0) r.ln = 14'(room);
            else r.ln = 14'($urandom_range(0, (room < 24) ? room : 24));
        end else if (roll < 9 && owned.size() != 0) begin
            r.op = OP_FREE;
            r.id = seg_tbl[owned[$urandom_range(0, owned.size() - 1)]].owner;
        end else begin
            // noise: any field value at all
            r.op = 1'($urandom);
            r.id = 16'($urandom);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_basic_ops();
        alloc_word(16'd1, 14'd0, 14'd100);          // front of the hole
        alloc_word(16'd2, 14'd200, 14'd50);         // split with trailing hole
        alloc_word(16'hFFFF, 14'd10000, 14'd240);   // split ending at the top
        alloc_word(16'd4, 14'd0, 14'h3FFF);         // nothing fits
        alloc_word(16'd5, 14'h3FFF, 14'h3FFF);      // start past the end
        alloc_word(16'd0, 14'd300, 14'd0);          // zero length region
        free_word(16'd99);                          // unknown owner
        free_word(16'd2);                           // holes on both sides
        free_word(16'd0);
        free_word(16'd1);
        free_word(16'hFFFF);
    endtask

    task automatic test_size_extremes();
        write_total(14'd1);
        alloc_word(16'd7, 14'd0, 14'd1);            // hole left with length zero
        alloc_word(16'd8, 14'd0, 14'd0);
        free_word(16'd7);
        free_word(16'd8);
        write_total(14'h3FFF);
        alloc_word(16'd1, 14'd0, 14'h3FFF);
        free_word(16'd1);                           // merges with the empty hole on its right
        alloc_word(16'd2, 14'd10, 14'd5);
        alloc_word(16'd3, 14'd15, 14'd5);
        free_word(16'd3);                           // merge with the right hole
        free_word(16'd2);                           // merge with the holes on both sides
    endtask

    task automatic test_table_full();
        write_total(14'd100);
        for (int k = 0; k < 16; k++) alloc_word(16'(k + 1), 14'(2 * k + 1), 14'd1);
        alloc_word(16'd40, 14'd30, 14'd2);
        alloc_word(16'd41, 14'd32, 14'd2);          // one entry too many
        for (int k = 0; k < 6; k++) free_word(16'(k + 1));
    endtask

    // Hold the output for a long stretch while words keep being offered.
    task automatic test_back_pressure();
        write_total(14'd512);
        @(negedge i_clk);
        hold_cycles = 300;
        repeat (20) send_word(pick_request());
        drain();
        repeat (10) send_word(pick_request());
        drain();
    endtask

    task automatic test_random_traffic();
        logic [13:0] sizes[4];
        sizes = '{14'h3FFF, 14'($urandom_range(1, 16383)), 14'd40, 14'($urandom)};
        if (sizes[3] == 0) sizes[3] = 14'd1;
        foreach (sizes[p]) begin
            write_total(sizes[p]);
            if (p == 3) quiet = 1;
            repeat (85) send_word(pick_request());
        end
    endtask

    initial begin
        rebuild_table(sha_pkg::TOTAL_RESET);
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_ops();
        test_size_extremes();
        test_table_full();
        test_back_pressure();
        test_random_traffic();
        drain();
        repeat (150) @(posedge i_clk);
        if (mismatch_count == 0 && status_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
